// ===== rtl/mjlr_pkg.sv =====
`timescale 1ns / 1ps
package mjlr_pkg;

    localparam int JOINT_COUNT = 6;
    localparam int POS_W       = 16;
    localparam int JIDX_W      = 3;
    localparam int PROG_W      = 17;
    localparam int DIV_STEPS   = 16;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_START = 3'd1,
        OP_TICK  = 3'd2,
        OP_STOP  = 3'd3,
        OP_QUERY = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_DONE = 2'd1,
        KIND_PROG = 2'd2
    } t_kind;

    typedef struct packed {
        logic accept;
        logic mask_ld;
        logic scan;
        logic mul;
        logic div_step;
        logic max_ld;
        logic q_setup;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic mask_zero;
        logic div_last;
        logic out_free;
        logic q_trivial;
        logic more_cmds;
    } t_sts;

endpackage

// ===== rtl/multi_joint_linear_ramp.sv =====
`timescale 1ns / 1ps
// Load, start and stop give no result; a tick while idle likewise.
// A tick while running loads the mask of moving joints; for each one it multiplies,
// divides in the shared 16-step restoring divider and emits; a done result ends it.
// A query divides by the longest duration when needed. One item is worked at a time.
// Synchronous active-low reset clears all joint targets, durations, time and the flag.
module multi_joint_linear_ramp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0]                          i_operation,
    input  logic [mjlr_pkg::JIDX_W-1:0]         i_joint,
    input  logic [mjlr_pkg::POS_W-1:0]          i_target_position,
    input  logic [mjlr_pkg::POS_W-1:0]          i_duration_ms,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_kind,
    output logic [mjlr_pkg::JIDX_W-1:0]         o_joint_index,
    output logic [mjlr_pkg::POS_W-1:0]          o_joint_position,
    output logic [mjlr_pkg::PROG_W-1:0]         o_progress_q16,
    output logic                                o_running,
    output logic                                o_last
);
    import mjlr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mjlr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_ready     (o_ready),
        .o_cmd       (cmd)
    );

    mjlr_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_operation       (i_operation),
        .i_joint           (i_joint),
        .i_target_position (i_target_position),
        .i_duration_ms     (i_duration_ms),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_joint_index     (o_joint_index),
        .o_joint_position  (o_joint_position),
        .o_progress_q16    (o_progress_q16),
        .o_running         (o_running),
        .o_last            (o_last)
    );

endmodule

// ===== rtl/mjlr_ctrl.sv =====
`timescale 1ns / 1ps
module mjlr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2:0]      i_operation,
    input  mjlr_pkg::t_sts  i_sts,
    output logic            o_ready,
    output mjlr_pkg::t_cmd  o_cmd
);
    import mjlr_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MASK = 8'b0000_0010,
        S_CHK  = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_MAX  = 8'b0010_0000,
        S_QCHK = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_op    op;

    assign op      = t_op'(i_operation);
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (op == OP_TICK && i_sts.active) begin
                        n_state = S_MASK;
                    end else if (op == OP_QUERY) begin
                        n_state = S_MAX;
                    end
                end
            end
            S_MASK: begin
                o_cmd.mask_ld = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.scan = 1'b1;
                n_state = i_sts.mask_zero ? S_EMIT : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_MAX: begin
                o_cmd.max_ld = 1'b1;
                n_state = S_QCHK;
            end
            S_QCHK: begin
                o_cmd.q_setup = 1'b1;
                n_state = i_sts.q_trivial ? S_EMIT : S_DIV;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = i_sts.more_cmds ? S_CHK : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/mjlr_dpath.sv =====
`timescale 1ns / 1ps
module mjlr_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mjlr_pkg::t_cmd                i_cmd,
    output mjlr_pkg::t_sts                o_sts,
    input  logic [2:0]                    i_operation,
    input  logic [mjlr_pkg::JIDX_W-1:0]   i_joint,
    input  logic [mjlr_pkg::POS_W-1:0]    i_target_position,
    input  logic [mjlr_pkg::POS_W-1:0]    i_duration_ms,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [1:0]                    o_kind,
    output logic [mjlr_pkg::JIDX_W-1:0]   o_joint_index,
    output logic [mjlr_pkg::POS_W-1:0]    o_joint_position,
    output logic [mjlr_pkg::PROG_W-1:0]   o_progress_q16,
    output logic                          o_running,
    output logic                          o_last
);
    import mjlr_pkg::*;

    logic [POS_W-1:0]       r_tgt [JOINT_COUNT];
    logic [POS_W-1:0]       r_dur [JOINT_COUNT];
    logic [POS_W-1:0]       r_elapsed;
    logic                   r_active;
    logic [JOINT_COUNT-1:0] r_mask;
    logic [JIDX_W-1:0]      r_sel;
    logic [POS_W-1:0]       r_mul_a;
    logic [POS_W-1:0]       r_div;
    logic [POS_W-1:0]       r_rem;
    logic [POS_W-1:0]       r_quo;
    logic [CNT_W-1:0]       r_cnt;
    t_kind                  r_kind;
    logic                   r_sat;
    logic                   r_out_valid;

    logic [JOINT_COUNT-1:0] n_mask;
    logic [JOINT_COUNT-1:0] mask_clr;
    logic [JIDX_W-1:0]      low_sel;
    logic [POS_W-1:0]       max_dur;
    logic [2*POS_W-1:0]     product;
    logic [POS_W:0]         trial;
    logic [POS_W:0]         diff;
    logic                   ge;
    logic                   out_free;
    t_op                    op;

    assign op = t_op'(i_operation);

    always_comb begin
        n_mask  = '0;
        low_sel = '0;
        max_dur = '0;
        for (int i = 0; i < JOINT_COUNT; i++) begin
            n_mask[i] = r_dur[i] > r_elapsed;
            if (r_dur[i] > max_dur) begin
                max_dur = r_dur[i];
            end
        end
        for (int i = JOINT_COUNT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_sel = JIDX_W'(i);
            end
        end
        mask_clr = r_mask;
        for (int i = 0; i < JOINT_COUNT; i++) begin
            if (JIDX_W'(i) == low_sel) begin
                mask_clr[i] = 1'b0;
            end
        end
    end

    assign product  = r_mul_a * r_elapsed;
    assign trial    = {r_rem, r_quo[POS_W-1]};
    assign diff     = trial - {1'b0, r_div};
    assign ge       = !diff[POS_W];
    assign out_free = !r_out_valid || i_ready;

    assign o_sts.active    = r_active;
    assign o_sts.mask_zero = (r_mask == '0);
    assign o_sts.div_last  = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_sts.out_free  = out_free;
    assign o_sts.q_trivial = !r_active || (r_div == '0) || (r_elapsed >= r_div);
    assign o_sts.more_cmds = (r_kind == KIND_CMD) && (r_mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < JOINT_COUNT; i++) begin
                r_tgt[i] <= '0;
                r_dur[i] <= '0;
            end
            r_elapsed   <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_mask      <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cmd.accept) begin
                unique case (op)
                    OP_LOAD: begin
                        if (32'(i_joint) < JOINT_COUNT) begin
                            r_tgt[i_joint] <= i_target_position;
                            r_dur[i_joint] <= i_duration_ms;
                        end
                    end
                    OP_START: begin
                        r_elapsed <= '0;
                        r_active  <= 1'b1;
                    end
                    OP_TICK: begin
                        if (r_elapsed != '1) begin
                            r_elapsed <= r_elapsed + 1'b1;
                        end
                    end
                    OP_STOP: r_active <= 1'b0;
                    default: ;
                endcase
            end
            if (i_cmd.mask_ld) begin
                r_mask <= n_mask;
            end
            if (i_cmd.scan && r_mask != '0) begin
                r_mask <= mask_clr;
            end
            if (i_cmd.mul || i_cmd.q_setup) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (r_kind == KIND_DONE) begin
                    r_active <= 1'b0;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            if (r_mask == '0) begin
                r_kind <= KIND_DONE;
            end else begin
                r_kind  <= KIND_CMD;
                r_sel   <= low_sel;
                r_mul_a <= r_tgt[low_sel];
                r_div   <= r_dur[low_sel];
            end
        end
        if (i_cmd.mul) begin
            r_rem <= product[2*POS_W-1:POS_W];
            r_quo <= product[POS_W-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
            r_quo <= {r_quo[POS_W-2:0], ge};
        end
        if (i_cmd.max_ld) begin
            r_div  <= max_dur;
            r_kind <= KIND_PROG;
        end
        if (i_cmd.q_setup) begin
            r_sat <= o_sts.q_trivial;
            r_rem <= r_elapsed;
            r_quo <= '0;
        end
        if (i_cmd.emit) begin
            o_kind           <= r_kind;
            o_joint_index    <= (r_kind == KIND_CMD) ? r_sel : '0;
            o_joint_position <= (r_kind == KIND_CMD) ? r_quo : '0;
            o_running        <= (r_kind == KIND_DONE) ? 1'b0 : r_active;
            o_last           <= (r_kind == KIND_CMD) ? (r_mask == '0) : 1'b1;
            if (r_kind == KIND_PROG) begin
                o_progress_q16 <= r_sat ? PROG_W'(1 << POS_W) : {1'b0, r_quo};
            end else begin
                o_progress_q16 <= '0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule
